// File: hw/rtl/oai_pkg.sv
// shared types, codes and constants for the orbit attractor iterator
`timescale 1ns / 1ps
package oai_pkg;

  localparam logic [1:0] MODE_HOP   = 2'd0;
  localparam logic [1:0] MODE_THREE = 2'd1;
  localparam logic [1:0] MODE_QUAD  = 2'd2;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_A     = 3'd1;
  localparam logic [2:0] REG_B     = 3'd2;
  localparam logic [2:0] REG_C     = 3'd3;
  localparam logic [2:0] REG_SCALE = 3'd4;
  localparam logic [2:0] REG_CBC   = 3'd5;
  localparam logic [2:0] REG_SABC  = 3'd6;

  localparam logic [31:0] SCALE_RESET = 32'h0100_0000;

  // angles and gains in signed q33.30
  localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
  localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
  localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
  localparam logic signed [63:0] Q30_KINV    = 64'sd652032874;
  localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;

  typedef enum logic [8:0] {
    OP_MUL   = 9'b000000001,
    OP_SQRT  = 9'b000000010,
    OP_SIN   = 9'b000000100,
    OP_ATAN  = 9'b000001000,
    OP_ORBIT = 9'b000010000,
    OP_SCX   = 9'b000100000,
    OP_SCY   = 9'b001000000,
    OP_DONE  = 9'b010000000
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_RED  = 4'b0010,
    C_FOLD = 4'b0100,
    C_ITER = 4'b1000
  } cor_state_t;

  typedef struct packed {
    logic start;
    logic vec;
  } cor_req_t;

  function automatic logic signed [63:0] atan_q30(input logic [4:0] idx);
    logic signed [63:0] v;
    case (idx)
      5'd0:  v = 64'sd843314857;
      5'd1:  v = 64'sd497837829;
      5'd2:  v = 64'sd263043837;
      5'd3:  v = 64'sd133525159;
      5'd4:  v = 64'sd67021687;
      5'd5:  v = 64'sd33543516;
      5'd6:  v = 64'sd16775851;
      5'd7:  v = 64'sd8388437;
      5'd8:  v = 64'sd4194283;
      5'd9:  v = 64'sd2097149;
      default: v = 64'sd1 <<< (5'd30 - idx);
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/oai_mul.sv
// shift-add multiplier, one multiplier bit per cycle, signed 33 x 33
`timescale 1ns / 1ps
module oai_mul import oai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic               done,
  output logic signed [65:0] prod
);

  logic [32:0] ma;
  logic [32:0] hi;
  logic [32:0] lo;
  logic        neg;
  logic [5:0]  cnt;
  logic [33:0] sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, ma} : 34'd0);
  assign prod = neg ? -$signed({hi, lo}) : $signed({hi, lo});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 6'd33;
      end else if (cnt != 6'd0) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[32] ? 33'(-a) : 33'(a);
      lo  <= b[32] ? 33'(-b) : 33'(b);
      hi  <= '0;
      neg <= a[32] ^ b[32];
    end else if (cnt != 6'd0) begin
      hi <= sum[33:1];
      lo <= {sum[0], lo[32:1]};
    end
  end

endmodule

// File: hw/rtl/oai_sqrt.sv
// floor square root of a 64-bit value, two radicand bits per cycle
`timescale 1ns / 1ps
module oai_sqrt import oai_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] sr;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic [35:0] remx;
  logic [35:0] trial;

  assign remx  = {rem, sr[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 6'd32;
      end else if (cnt != 6'd0) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr   <= rad;
      rem  <= '0;
      root <= '0;
    end else if (cnt != 6'd0) begin
      sr <= {sr[61:0], 2'b00};
      if (remx >= trial) begin
        rem  <= 34'(remx - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= remx[33:0];
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

// File: hw/rtl/oai_cordic.sv
// iterative cordic: sine (rotation, with angle reduction) and arctangent (vectoring)
`timescale 1ns / 1ps
module oai_cordic import oai_pkg::*; #(
  parameter int CORDIC_ITERS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cor_req_t           req,
  input  logic signed [31:0] arg,
  output logic               done,
  output logic signed [31:0] res
);

  localparam int SH = 30 - FRAC_BITS;
  localparam int KR = 30 - FRAC_BITS;
  localparam int KW = $clog2(KR + 1);
  localparam int IW = $clog2(CORDIC_ITERS);

  cor_state_t         cst;
  logic               vmode;
  logic               neg;
  logic [63:0]        rem;
  logic [KW-1:0]      k;
  logic [IW-1:0]      i;
  logic signed [63:0] x, y, z;
  logic signed [63:0] vin;
  logic [63:0]        modv;
  logic signed [63:0] r0, r1, rf;
  logic signed [63:0] dx, dy, tab;
  logic signed [63:0] x_next, y_next, z_next;
  logic               dir;

  assign vin  = 64'(arg) <<< SH;
  assign modv = 64'(Q30_TWO_PI) << k;

  always_comb begin
    // fold the reduced angle into [-pi/2, pi/2]
    r0 = neg ? -$signed(rem) : $signed(rem);
    r1 = r0;
    if (r0 > Q30_PI) begin
      r1 = r0 - Q30_TWO_PI;
    end else if (r0 < -Q30_PI) begin
      r1 = r0 + Q30_TWO_PI;
    end
    rf = r1;
    if (r1 > Q30_HALF_PI) begin
      rf = Q30_PI - r1;
    end else if (r1 < -Q30_HALF_PI) begin
      rf = -Q30_PI - r1;
    end
  end

  always_comb begin
    dx  = y >>> i;
    dy  = x >>> i;
    tab = atan_q30(5'(i));
    dir = vmode ? (y >= 0) : (z >= 0);
    if (vmode == dir) begin
      x_next = x + dx;
      y_next = y - dy;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
    end
    z_next = dir ? z + (vmode ? tab : -tab) : z - (vmode ? tab : -tab);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst  <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (cst)
        C_IDLE: begin
          if (req.start) begin
            cst <= req.vec ? C_ITER : C_RED;
          end
        end
        C_RED: begin
          if (k == '0) begin
            cst <= C_FOLD;
          end
        end
        C_FOLD: cst <= C_ITER;
        C_ITER: begin
          if (i == IW'(CORDIC_ITERS - 1)) begin
            cst  <= C_IDLE;
            done <= 1'b1;
          end
        end
        default: cst <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cst)
      C_IDLE: begin
        if (req.start) begin
          vmode <= req.vec;
          neg   <= vin < 0;
          rem   <= (vin < 0) ? 64'(-vin) : 64'(vin);
          k     <= KW'(KR);
          x     <= Q30_ONE;
          y     <= vin;
          z     <= '0;
          i     <= '0;
        end
      end
      C_RED: begin
        // truncating remainder by 2*pi, one power-of-two multiple per cycle
        if (rem >= modv) begin
          rem <= rem - modv;
        end
        k <= k - KW'(1);
      end
      C_FOLD: begin
        x <= Q30_KINV;
        y <= '0;
        z <= rf;
        i <= '0;
      end
      C_ITER: begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        i <= i + IW'(1);
        res <= vmode ? 32'(z_next >>> SH) : 32'(y_next >>> SH);
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/orbit_attractor_iterator.sv
// top level: configuration registers, step sequencer and orbit state
`timescale 1ns / 1ps
// Each accepted transaction (step_trig, restart) yields one result transaction (pos_x, pos_y).
// Restart clears the orbit and the held outputs; without step_trig the transaction goes
// straight to S_OUT, which registers the held point onto pos_x, pos_y and raises out_valid.
// A step runs its operations one at a time through one shared shift-add multiplier, a
// two-bit-per-cycle square root (hopalong only) and an iterative cordic (sine in threeply
// and quadrup, with angle reduction and fold; arctangent in quadrup only).
// Items are taken one at a time; configuration is written with cfg_ready always high.
module orbit_attractor_iterator import oai_pkg::*; #(
  parameter int CORDIC_ITERS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               step_trig,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y
);

  localparam int TW = 68;
  localparam logic signed [TW-1:0] S32_MAX = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] S32_MIN = -TW'(64'sd2147483648);

  function automatic logic signed [31:0] sat32(input logic signed [TW-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  function automatic logic signed [TW-1:0] absv(input logic signed [TW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [TW-1:0] min31(input logic signed [TW-1:0] v);
    return (v > S32_MAX) ? S32_MAX : v;
  endfunction

  function automatic op_t prog_op(input logic [1:0] mode, input logic [3:0] step);
    op_t op;
    op = OP_DONE;
    case (mode)
      MODE_THREE: begin
        case (step)
          4'd0: op = OP_SIN;
          4'd1: op = OP_MUL;
          4'd2: op = OP_MUL;
          4'd3: op = OP_ORBIT;
          4'd4: op = OP_SCX;
          4'd5: op = OP_SCY;
          default: op = OP_DONE;
        endcase
      end
      MODE_QUAD: begin
        case (step)
          4'd0: op = OP_MUL;
          4'd1: op = OP_MUL;
          4'd2: op = OP_ATAN;
          4'd3: op = OP_MUL;
          4'd4: op = OP_MUL;
          4'd5: op = OP_SIN;
          4'd6: op = OP_ORBIT;
          4'd7: op = OP_SCX;
          4'd8: op = OP_SCY;
          default: op = OP_DONE;
        endcase
      end
      default: begin
        case (step)
          4'd0: op = OP_MUL;
          4'd1: op = OP_SQRT;
          4'd2: op = OP_ORBIT;
          4'd3: op = OP_SCX;
          4'd4: op = OP_SCY;
          default: op = OP_DONE;
        endcase
      end
    endcase
    return op;
  endfunction

  // configuration
  logic [1:0]         map_mode;
  logic signed [31:0] coef_a, coef_b, coef_c, cos_b_plus_c, sin_a_b_c;
  logic [31:0]        out_scale;

  // orbit state and scratch
  state_t              state;
  logic [3:0]          pc;
  logic signed [31:0]  orbit_x, orbit_y, held_x, held_y;
  logic signed [TW-1:0] ta, tb, mag;

  op_t                 op;
  logic                mul_start, mul_done, sqrt_start, sqrt_done, cor_done;
  cor_req_t            cor_req;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  mprod;
  logic [31:0]         root;
  logic signed [31:0]  cor_arg, cor_res;
  logic [TW-1:0]       rad_sh;
  logic signed [TW-1:0] prf, sm;
  logic                unit_done;
  logic                in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign op        = prog_op(map_mode, pc);
  assign prf       = TW'(mprod >>> FRAC_BITS);
  assign rad_sh    = ta <<< FRAC_BITS;
  assign unit_done = mul_done || sqrt_done || cor_done;
  assign cor_arg   = (map_mode == MODE_THREE) ? orbit_x : 32'(ta);
  assign sm        = (orbit_x > 0) ? mag : ((orbit_x < 0) ? -mag : '0);

  assign mul_start    = (state == S_ISSUE) &&
                        (op == OP_MUL || op == OP_SCX || op == OP_SCY);
  assign sqrt_start   = (state == S_ISSUE) && (op == OP_SQRT);
  assign cor_req.start = (state == S_ISSUE) && (op == OP_SIN || op == OP_ATAN);
  assign cor_req.vec   = (op == OP_ATAN);

  always_comb begin
    mul_a = 33'(orbit_x);
    mul_b = $signed({1'b0, out_scale});
    if (op == OP_SCY) begin
      mul_a = 33'(orbit_y);
    end else if (op == OP_MUL) begin
      case (map_mode)
        MODE_THREE: begin
          if (pc == 4'd1) begin
            mul_a = ta[32:0];
            mul_b = 33'(cos_b_plus_c);
          end else begin
            mul_b = 33'(sin_a_b_c);
          end
        end
        MODE_QUAD: begin
          case (pc)
            4'd0:    mul_b = 33'(coef_c);
            4'd1: begin
              mul_a = ta[32:0];
              mul_b = ta[32:0];
            end
            4'd3:    mul_b = 33'(coef_b);
            default: begin
              mul_a = tb[32:0];
              mul_b = ta[32:0];
            end
          endcase
        end
        default: mul_b = 33'(coef_b);
      endcase
    end
  end

  oai_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mprod)
  );

  oai_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (rad_sh[63:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  oai_cordic #(
    .CORDIC_ITERS (CORDIC_ITERS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (cor_req),
    .arg  (cor_arg),
    .done (cor_done),
    .res  (cor_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode     <= MODE_HOP;
      coef_a       <= '0;
      coef_b       <= '0;
      coef_c       <= '0;
      out_scale    <= SCALE_RESET;
      cos_b_plus_c <= '0;
      sin_a_b_c    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:  map_mode     <= cfg_data[1:0];
        REG_A:     coef_a       <= cfg_data;
        REG_B:     coef_b       <= cfg_data;
        REG_C:     coef_c       <= cfg_data;
        REG_SCALE: out_scale    <= cfg_data;
        REG_CBC:   cos_b_plus_c <= cfg_data;
        REG_SABC:  sin_a_b_c    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
      orbit_x   <= '0;
      orbit_y   <= '0;
      held_x    <= '0;
      held_y    <= '0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            pc <= '0;
            if (restart) begin
              orbit_x <= '0;
              orbit_y <= '0;
              held_x  <= '0;
              held_y  <= '0;
            end
            state <= step_trig ? S_ISSUE : S_OUT;
          end
        end
        S_ISSUE: begin
          if (op == OP_DONE) begin
            state <= S_OUT;
          end else if (op == OP_ORBIT) begin
            orbit_x <= sat32(TW'(orbit_y) - sm);
            orbit_y <= sat32(TW'(coef_a) - TW'(orbit_x));
            pc      <= pc + 4'd1;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            pc    <= pc + 4'd1;
            state <= S_ISSUE;
            if (op == OP_SCX) begin
              held_x <= sat32(TW'(mprod >>> 24));
            end else if (op == OP_SCY) begin
              held_y <= sat32(TW'(mprod >>> 24));
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // scratch writeback from the arithmetic units
  always_ff @(posedge clk) begin
    if (state == S_WAIT && unit_done) begin
      case (map_mode)
        MODE_THREE: begin
          case (pc)
            4'd0:    ta  <= TW'(cor_res);
            4'd1:    ta  <= prf;
            4'd2:    mag <= absv(ta - prf);
            default: ;
          endcase
        end
        MODE_QUAD: begin
          case (pc)
            4'd0:    ta  <= min31(absv(prf - TW'(coef_b)));
            4'd1:    ta  <= min31(prf);
            4'd2:    ta  <= TW'(cor_res);
            4'd3:    tb  <= min31(absv(prf - TW'(coef_c)));
            4'd4:    ta  <= TW'(sat32(prf));
            4'd5:    mag <= TW'(cor_res);
            default: ;
          endcase
        end
        default: begin
          case (pc)
            4'd0:    ta  <= absv(prf - TW'(coef_c));
            4'd1:    mag <= TW'($signed({1'b0, root}));
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      pos_x <= held_x;
      pos_y <= held_y;
    end
  end

  // only one arithmetic unit finishes at a time
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_done, sqrt_done, cor_done}))
    else $error("more than one unit done");

  // a transaction without a step goes straight to the output
  a_no_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !step_trig |=> state == S_OUT)
    else $error("idle transaction did not go to output");

  // restart without a step clears the held point
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && restart && !step_trig |=> held_x == 0 && held_y == 0 && orbit_x == 0)
    else $error("restart did not clear state");

  // a unit only finishes while the sequencer waits on it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> state == S_WAIT)
    else $error("unit finished outside wait");

endmodule
